/* rtl/core/brb_pkg.sv */
// ----------------------------------------------------------------------------
// brb_pkg
// Shared widths, item kind codes and the front-to-back command record of the
// circular byte buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int KIND_W  = 3;
   localparam int LEN_W   = 13;
   localparam int BYTE_W  = 8;
   localparam int PCT_W   = 7;

   // widest values any legal DEPTH / MAX_BURST can need
   localparam int POS_MAX_W   = 16;
   localparam int CNT_MAX_W   = 17;
   localparam int BURST_MAX_W = 7;

   localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_WBYTE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

   localparam int PCT_SCALE  = 100;
   localparam int QDIV_STEPS = 7;
   localparam int QDIV_CNT_W = 3;

   typedef struct packed {
      logic                   is_run;  // read or peek with at least one byte
      logic [BURST_MAX_W-1:0] n;
      logic [POS_MAX_W-1:0]   start;
      logic [LEN_W-1:0]       moved;
      logic                   we;
      logic [POS_MAX_W-1:0]   waddr;
      logic [BYTE_W-1:0]      wdata;
      logic [CNT_MAX_W-1:0]   held;    // bytes held after the item
   } cmd_type;

endpackage

/* rtl/core/brb_if.sv */
// ----------------------------------------------------------------------------
// brb_if
// Valid/ready channels of the circular byte buffer: request and response.
// ----------------------------------------------------------------------------
interface brb_req_if;
   import brb_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [LEN_W-1:0]  request_length;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, kind, request_length, data_byte, input ready);
   modport sink   (input valid, kind, request_length, data_byte, output ready);
endinterface

interface brb_rsp_if;
   import brb_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte_res;
   logic              byte_valid;
   logic [LEN_W-1:0]  moved_count;
   logic              last;
   logic [LEN_W-1:0]  stored_count;
   logic [LEN_W-1:0]  free_space;
   logic [PCT_W-1:0]  used_percent;

   modport source (output valid, data_byte_res, byte_valid, moved_count, last,
                   stored_count, free_space, used_percent, input ready);
   modport sink   (input valid, data_byte_res, byte_valid, moved_count, last,
                   stored_count, free_space, used_percent, output ready);
endinterface

/* rtl/core/brb_ram.sv */
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/brb_queue.sv */
// ----------------------------------------------------------------------------
// brb_queue
// Two-entry command queue between the classifying front and the back end.
// ----------------------------------------------------------------------------
module brb_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  brb_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output brb_pkg::cmd_type pop_cmd
);
   import brb_pkg::*;

   localparam logic [1:0] QUEUE_DEPTH = 2'd2;

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign push_ready = (cnt_ff != QUEUE_DEPTH);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_cmd    = mem_ff[rp_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop  ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/core/brb_front.sv */
// ----------------------------------------------------------------------------
// brb_front
// Accepts request items, owns pointers and fill counters, decides each item
// (block accepted or refused, byte stored or dropped, run length) and hands
// a command to the queue.
// ----------------------------------------------------------------------------
module brb_front #(
   parameter int DEPTH     = 4096,
   parameter int MAX_BURST = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [brb_pkg::LEN_W-1:0]    csr_wr_data,
   brb_req_if.sink                      req,
   output logic                         push_valid,
   input  logic                         push_ready,
   output brb_pkg::cmd_type             push_cmd,
   output logic [$clog2(DEPTH+1)-1:0]   capacity
);
   import brb_pkg::*;

   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH+1);
   localparam int CMP_W   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
   localparam int BURST_W = $clog2(MAX_BURST+1);

   logic [CNT_W-1:0]  cap_ff, cap_in;
   logic [ADDR_W-1:0] rd_ff, rd_in;
   logic [ADDR_W-1:0] wr_ff, wr_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [CNT_W-1:0]  pend_ff, pend_in;

   logic              accept;
   logic [CMP_W-1:0]  len_c, held_c, free_c, min_c;
   logic              open_ok, wb_ok;
   logic [BURST_W-1:0] n_c;
   logic [CNT_W-1:0]  wr_inc;
   logic [ADDR_W-1:0] wr_next;
   logic [CNT_W:0]    rd_sum;
   logic [ADDR_W-1:0] rd_adv;
   logic [CNT_W-1:0]  cap_sat;
   cmd_type           cmd;

   assign req.ready  = push_ready;
   assign accept     = req.valid && push_ready;
   assign push_valid = accept;
   assign push_cmd   = cmd;
   assign capacity   = cap_ff;

   always_comb begin
      len_c   = CMP_W'(req.request_length);
      held_c  = CMP_W'(held_ff);
      free_c  = CMP_W'(cap_ff - held_ff);
      open_ok = (free_c >= len_c);
      wb_ok   = (pend_ff != '0) && (held_ff < cap_ff);

      min_c = (len_c < held_c) ? len_c : held_c;
      n_c   = (min_c > CMP_W'(MAX_BURST)) ? BURST_W'(MAX_BURST) : BURST_W'(min_c);

      wr_inc  = CNT_W'(wr_ff) + CNT_W'(1);
      wr_next = (wr_inc >= cap_ff) ? '0 : ADDR_W'(wr_inc);

      // n never exceeds held, so one subtract brings the sum back in range
      rd_sum = (CNT_W+1)'(rd_ff) + (CNT_W+1)'(n_c);
      rd_adv = (rd_sum >= (CNT_W+1)'(cap_ff)) ?
               ADDR_W'(rd_sum - (CNT_W+1)'(cap_ff)) : ADDR_W'(rd_sum);

      cap_sat = (CMP_W'(csr_wr_data) > CMP_W'(DEPTH)) ? CNT_W'(DEPTH)
                                                      : CNT_W'(csr_wr_data);
   end

   always_comb begin
      cap_in  = cap_ff;
      rd_in   = rd_ff;
      wr_in   = wr_ff;
      held_in = held_ff;
      pend_in = pend_ff;
      cmd     = '0;

      case (req.kind)
         KIND_OPEN: begin
            if (open_ok) begin
               pend_in   = CNT_W'(req.request_length);
               cmd.moved = req.request_length;
            end else begin
               pend_in = '0;
            end
         end
         KIND_WBYTE: begin
            if (wb_ok) begin
               cmd.we    = 1'b1;
               cmd.waddr = POS_MAX_W'(wr_ff);
               cmd.wdata = req.data_byte;
               cmd.moved = LEN_W'(1);
               wr_in     = wr_next;
               held_in   = held_ff + CNT_W'(1);
               pend_in   = pend_ff - CNT_W'(1);
            end
         end
         KIND_READ, KIND_PEEK: begin
            if (n_c != '0) begin
               cmd.is_run = 1'b1;
               cmd.n      = BURST_MAX_W'(n_c);
               cmd.start  = POS_MAX_W'(rd_ff);
               if (req.kind == KIND_READ) begin
                  rd_in   = rd_adv;
                  held_in = held_ff - CNT_W'(n_c);
               end
            end
         end
         KIND_CLEAR: begin
            rd_in   = '0;
            wr_in   = '0;
            held_in = '0;
            pend_in = '0;
         end
         default: begin
         end
      endcase

      cmd.held = CNT_MAX_W'(held_in);

      if (csr_wr_en) begin
         cap_in  = cap_sat;
         rd_in   = '0;
         wr_in   = '0;
         held_in = '0;
         pend_in = '0;
      end else if (!accept) begin
         rd_in   = rd_ff;
         wr_in   = wr_ff;
         held_in = held_ff;
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= '0;
         rd_ff   <= '0;
         wr_ff   <= '0;
         held_ff <= '0;
         pend_ff <= '0;
      end else begin
         cap_ff  <= cap_in;
         rd_ff   <= rd_in;
         wr_ff   <= wr_in;
         held_ff <= held_in;
         pend_ff <= pend_in;
      end
   end

endmodule

/* rtl/core/brb_back.sv */
// ----------------------------------------------------------------------------
// brb_back
// Carries out queued commands: writes stored bytes, works out the fill
// percentage with a bit-per-cycle divider, streams read/peek runs from the
// RAM and holds each result in an output register.
// ----------------------------------------------------------------------------
module brb_back #(
   parameter int DEPTH     = 4096,
   parameter int MAX_BURST = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  brb_pkg::cmd_type             pop_cmd,
   input  logic [$clog2(DEPTH+1)-1:0]   capacity,
   output logic                         ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]     ram_wr_addr,
   output logic [brb_pkg::BYTE_W-1:0]   ram_wr_data,
   output logic                         ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]     ram_rd_addr,
   input  logic [brb_pkg::BYTE_W-1:0]   ram_rd_data,
   brb_rsp_if.source                    rsp
);
   import brb_pkg::*;

   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH+1);
   localparam int BURST_W = $clog2(MAX_BURST+1);
   localparam int D_W     = CNT_W + PCT_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_ONE  = 2'd2;
   localparam logic [1:0] ST_RUN  = 2'd3;

   logic [1:0]            st_ff, st_in;
   cmd_type               cmd_ff, cmd_in;
   logic [D_W-1:0]        rem_ff, rem_in;
   logic [D_W-1:0]        dvs_ff, dvs_in;
   logic [PCT_W-1:0]      quo_ff, quo_in;
   logic [QDIV_CNT_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [BURST_W-1:0]    issued_ff, issued_in;
   logic [BURST_W-1:0]    emitted_ff, emitted_in;
   logic                  pend_ff, pend_in;

   logic                  out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0]     out_data_ff;
   logic                  out_bvalid_ff;
   logic [LEN_W-1:0]      out_moved_ff;
   logic                  out_last_ff;
   logic [LEN_W-1:0]      out_stored_ff;
   logic [LEN_W-1:0]      out_free_ff;
   logic [PCT_W-1:0]      out_pct_ff;

   logic                  pop, can_load, take, issue, load_one, trial_ok, run_end;
   logic [BURST_W-1:0]    n_c;
   logic [CNT_W-1:0]      held_c, free_c, pos_inc;
   logic [ADDR_W-1:0]     pos_next;
   logic [PCT_W-1:0]      pct_c;

   always_comb begin
      n_c      = cmd_ff.n[BURST_W-1:0];
      held_c   = cmd_ff.held[CNT_W-1:0];
      free_c   = capacity - held_c;
      pct_c    = (capacity == '0) ? '0 : quo_ff;
      can_load = !out_valid_ff || rsp.ready;
      pop      = pop_valid && (st_ff == ST_IDLE);
      take     = (st_ff == ST_RUN) && pend_ff && can_load;
      issue    = (st_ff == ST_RUN) && (issued_ff < n_c) && (!pend_ff || take);
      load_one = (st_ff == ST_ONE) && can_load;
      run_end  = ((emitted_ff + BURST_W'(1)) == n_c);
      trial_ok = (rem_ff >= dvs_ff);
      pos_inc  = CNT_W'(pos_ff) + CNT_W'(1);
      pos_next = (pos_inc >= capacity) ? '0 : ADDR_W'(pos_inc);
   end

   assign pop_ready   = (st_ff == ST_IDLE);
   assign ram_wr_en   = pop && pop_cmd.we;
   assign ram_wr_addr = pop_cmd.waddr[ADDR_W-1:0];
   assign ram_wr_data = pop_cmd.wdata;
   assign ram_rd_en   = issue;
   assign ram_rd_addr = pos_ff;

   always_comb begin
      st_in      = st_ff;
      cmd_in     = cmd_ff;
      rem_in     = rem_ff;
      dvs_in     = dvs_ff;
      quo_in     = quo_ff;
      step_in    = step_ff;
      pos_in     = pos_ff;
      issued_in  = issued_ff;
      emitted_in = emitted_ff;
      pend_in    = pend_ff;

      case (st_ff)
         ST_IDLE: begin
            if (pop) begin
               cmd_in  = pop_cmd;
               rem_in  = D_W'(pop_cmd.held[CNT_W-1:0]) * D_W'(PCT_SCALE);
               dvs_in  = D_W'(capacity) << (QDIV_STEPS - 1);
               quo_in  = '0;
               step_in = '0;
               st_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring division, quotient bit per cycle, msb first
            if (trial_ok) begin
               rem_in = rem_ff - dvs_ff;
            end
            quo_in  = {quo_ff[PCT_W-2:0], trial_ok};
            dvs_in  = dvs_ff >> 1;
            step_in = step_ff + QDIV_CNT_W'(1);
            if (step_ff == QDIV_CNT_W'(QDIV_STEPS - 1)) begin
               st_in      = cmd_ff.is_run ? ST_RUN : ST_ONE;
               pos_in     = cmd_ff.start[ADDR_W-1:0];
               issued_in  = '0;
               emitted_in = '0;
               pend_in    = 1'b0;
            end
         end
         ST_ONE: begin
            if (can_load) begin
               st_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            // pend: RAM read data holds a byte not yet moved to the output
            if (issue) begin
               pos_in    = pos_next;
               issued_in = issued_ff + BURST_W'(1);
               pend_in   = 1'b1;
            end else if (take) begin
               pend_in = 1'b0;
            end
            if (take) begin
               emitted_in = emitted_ff + BURST_W'(1);
               if (run_end) begin
                  st_in = ST_IDLE;
               end
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (load_one || take) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         step_ff      <= '0;
         issued_ff    <= '0;
         emitted_ff   <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         step_ff      <= step_in;
         issued_ff    <= issued_in;
         emitted_ff   <= emitted_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      pos_ff <= pos_in;
      if (load_one) begin
         out_data_ff   <= '0;
         out_bvalid_ff <= 1'b0;
         out_moved_ff  <= cmd_ff.moved;
         out_last_ff   <= 1'b1;
      end else if (take) begin
         out_data_ff   <= ram_rd_data;
         out_bvalid_ff <= 1'b1;
         out_moved_ff  <= LEN_W'(n_c);
         out_last_ff   <= run_end;
      end
      if (load_one || take) begin
         out_stored_ff <= LEN_W'(held_c);
         out_free_ff   <= LEN_W'(free_c);
         out_pct_ff    <= pct_c;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.data_byte_res = out_data_ff;
   assign rsp.byte_valid    = out_bvalid_ff;
   assign rsp.moved_count   = out_moved_ff;
   assign rsp.last          = out_last_ff;
   assign rsp.stored_count  = out_stored_ff;
   assign rsp.free_space    = out_free_ff;
   assign rsp.used_percent  = out_pct_ff;

endmodule

/* rtl/core/byte_ring_buffer_all_or_nothing_write.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer_all_or_nothing_write
// Circular byte FIFO with a programmable ring size and whole-block writes.
//
//   channel   dir  handshake           payload
//   req_chan  in   valid/ready         kind, request_length, data_byte
//   rsp_chan  out  valid/ready         data_byte_res, byte_valid, moved_count,
//                                      last, stored_count, free_space,
//                                      used_percent
//   csr_*     in   csr_wr_en (no wait) csr_wr_data = capacity_in_use
//
// The front takes one item per cycle while its two-entry queue has room.
// The back takes one item at a time: it pops a command, runs 7 divider steps
// for used_percent, then loads a single result into the output register or,
// for a run of n bytes, issues RAM reads and moves one byte per cycle from the
// RAM read port while the response side takes them, before it pops the next.
// Reset is synchronous; the ring contents are not cleared.
// Response stalls hold the output register and back up through the queue.
// ----------------------------------------------------------------------------
module byte_ring_buffer_all_or_nothing_write #(
   parameter int DEPTH     = 4096,
   parameter int MAX_BURST = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [brb_pkg::LEN_W-1:0] csr_wr_data,
   brb_req_if.sink                   req_chan,
   brb_rsp_if.source                 rsp_chan
);
   import brb_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH+1);

   logic              push_valid, push_ready, pop_valid, pop_ready;
   cmd_type           push_cmd, pop_cmd;
   logic [CNT_W-1:0]  capacity;
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [BYTE_W-1:0] ram_wr_data, ram_rd_data;

   brb_front #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_chan),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd),
      .capacity    (capacity)
   );

   brb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   brb_back #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_cmd     (pop_cmd),
      .capacity    (capacity),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp         (rsp_chan)
   );

   brb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

/* bench/byte_ring_buffer_all_or_nothing_write_tb.sv */
// ----------------------------------------------------------------------------
// byte_ring_buffer_all_or_nothing_write_tb
// Self-checking bench for the circular byte buffer with whole-block writes.
// A queue-fed driver offers items on the request channel and a clocked
// monitor checks every response against a cycle-free predictor of the ring
// (capacity, pointers, held and pending byte counts, percent filled).
// Directed corner items come first, then randomized block-write and
// read/peek traffic over several ring sizes and idle/stall mixes, including
// a long response hold-off that backs the buffer up.
// ----------------------------------------------------------------------------
module byte_ring_buffer_all_or_nothing_write_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import brb_pkg::*;

   localparam int RING_DEPTH    = 4096;
   localparam int BURST_LIMIT   = 64;
   localparam int SETTLE_CYCLES = 80;     // drain time for the longest run, plus margin
   localparam int STALL_LIMIT   = 4000;
   localparam int REPORT_LIMIT  = 10;
   localparam int LEN_ALL_ONES  = 8191;

   // kind codes the block has no meaning for
   localparam logic [KIND_W-1:0] KIND_SPARE5 = 3'd5;
   localparam logic [KIND_W-1:0] KIND_SPARE6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE7 = 3'd7;

   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] data;
   } buf_op_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              byte_valid;
      logic [LEN_W-1:0]  moved;
      logic              last;
      logic [LEN_W-1:0]  stored;
      logic [LEN_W-1:0]  space;
      logic [PCT_W-1:0]  pct;
   } buf_status_type;

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [LEN_W-1:0] csr_wr_data;

   brb_req_if req_chan ();
   brb_rsp_if rsp_chan ();

   byte_ring_buffer_all_or_nothing_write dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   buf_op_type     op_q [$];
   buf_status_type due_q [$];

   // predicted ring state
   bit [BYTE_W-1:0] ring_mem [RING_DEPTH];
   int ring_cap   = 0;
   int ring_held  = 0;
   int rd_ptr     = 0;
   int wr_ptr     = 0;
   int block_left = 0;

   // rough fill level seen by the stimulus side, used to shape sequences
   int plan_cap   = 0;
   int plan_held  = 0;
   int plan_block = 0;

   int send_gap_pct   = 0;
   int take_stall_pct = 0;
   int hold_len       = 0;
   bit hold_req       = 1'b0;
   bit hold_ack       = 1'b0;
   int hold_left      = 0;
   bit req_took       = 1'b0;

   int fault_count   = 0;
   int checked_count = 0;
   int byte_count    = 0;
   int item_count    = 0;
   int cap_settings  = 0;
   int quiet_cycles  = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic int ring_step(int pos);
      return (pos + 1 >= ring_cap) ? 0 : pos + 1;
   endfunction

   function automatic void clear_ring();
      rd_ptr     = 0;
      wr_ptr     = 0;
      ring_held  = 0;
      block_left = 0;
   endfunction

   // status fields always reflect the ring after the whole item
   function automatic void post_status(logic [BYTE_W-1:0] data, logic bv, int moved,
                                       logic last);
      buf_status_type s;
      s.data       = data;
      s.byte_valid = bv;
      s.moved      = LEN_W'(moved);
      s.last       = last;
      s.stored     = LEN_W'(ring_held);
      s.space      = LEN_W'(ring_cap - ring_held);
      s.pct        = (ring_cap == 0) ? '0 : PCT_W'((ring_held * PCT_SCALE) / ring_cap);
      due_q.push_back(s);
   endfunction

   function automatic void predict_buffer_op(buf_op_type op);
      int n;
      int pos;
      bit [BYTE_W-1:0] run [BURST_LIMIT];
      case (op.kind)
         KIND_OPEN: begin
            if (ring_cap - ring_held >= int'(op.len)) begin
               block_left = op.len;
               post_status('0, 1'b0, op.len, 1'b1);
            end else begin
               block_left = 0;
               post_status('0, 1'b0, 0, 1'b1);
            end
         end
         KIND_WBYTE: begin
            if (block_left != 0 && ring_held < ring_cap) begin
               ring_mem[wr_ptr] = op.data;
               wr_ptr = ring_step(wr_ptr);
               ring_held++;
               block_left--;
               post_status('0, 1'b0, 1, 1'b1);
            end else begin
               post_status('0, 1'b0, 0, 1'b1);
            end
         end
         KIND_READ, KIND_PEEK: begin
            n = op.len;
            if (n > ring_held) n = ring_held;
            if (n > BURST_LIMIT) n = BURST_LIMIT;
            pos = rd_ptr;
            for (int i = 0; i < n; i++) begin
               run[i] = ring_mem[pos];
               pos = ring_step(pos);
            end
            if (op.kind == KIND_READ) begin
               rd_ptr = pos;
               ring_held -= n;
            end
            if (n == 0) post_status('0, 1'b0, 0, 1'b1);
            for (int i = 0; i < n; i++) post_status(run[i], 1'b1, n, i == n - 1);
         end
         KIND_CLEAR: begin
            clear_ring();
            post_status('0, 1'b0, 0, 1'b1);
         end
         default: post_status('0, 1'b0, 0, 1'b1);
      endcase
   endfunction

   function automatic string show_status(buf_status_type s);
      return $sformatf("data %02h bv %0d moved %0d last %0d stored %0d free %0d pct %0d",
                       s.data, s.byte_valid, s.moved, s.last, s.stored, s.space, s.pct);
   endfunction

   // ---------------- monitor: check results, track config and items ----------------
   always @(posedge clock) begin
      buf_status_type got;
      buf_status_type want;
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.data       = rsp_chan.data_byte_res;
            got.byte_valid = rsp_chan.byte_valid;
            got.moved      = rsp_chan.moved_count;
            got.last       = rsp_chan.last;
            got.stored     = rsp_chan.stored_count;
            got.space      = rsp_chan.free_space;
            got.pct        = rsp_chan.used_percent;
            checked_count++;
            if (got.byte_valid === 1'b1) byte_count++;
            if (due_q.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("%0t: result with nothing expected: %s", $realtime,
                           show_status(got));
            end else begin
               want = due_q.pop_front();
               if (got.data !== want.data || got.byte_valid !== want.byte_valid ||
                   got.moved !== want.moved || got.last !== want.last ||
                   got.stored !== want.stored || got.space !== want.space ||
                   got.pct !== want.pct) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("%0t: result mismatch", $realtime);
                     $display("   expected %s", show_status(want));
                     $display("   actual   %s", show_status(got));
                  end
               end
            end
         end
         if (csr_wr_en) begin
            ring_cap = (csr_wr_data > RING_DEPTH) ? RING_DEPTH : csr_wr_data;
            clear_ring();
         end
         if (req_chan.valid && req_chan.ready) begin
            item_count++;
            predict_buffer_op('{req_chan.kind, req_chan.request_length,
                                req_chan.data_byte});
         end
      end
   end

   // ---------------- request driver ----------------
   always @(negedge clock) begin
      buf_op_type head;
      bit         offer;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_took) void'(op_q.pop_front());
         // an item not yet taken stays on the channel unchanged
         if (!req_chan.valid || req_took) begin
            offer = op_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct;
            if (offer) begin
               head = op_q[0];
               req_chan.kind           <= head.kind;
               req_chan.request_length <= head.len;
               req_chan.data_byte      <= head.data;
               req_chan.valid          <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- response ready: random stalls plus long hold-off ----------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
         hold_ack       <= hold_req;
         hold_left      <= hold_len;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= $urandom_range(0, 99) >= take_stall_pct;
      end
   end

   // ---------------- watchdog: no handshake while work is outstanding ----------------
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (op_q.size() == 0 && !req_chan.valid && due_q.size() == 0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: timeout, no handshake for %0d cycles", $realtime, quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   function automatic void queue_op(logic [KIND_W-1:0] kind, int len, int data);
      int n;
      op_q.push_back('{kind, LEN_W'(len), BYTE_W'(data)});
      case (kind)
         KIND_OPEN:  plan_block = (plan_cap - plan_held >= len) ? len : 0;
         KIND_WBYTE: begin
            if (plan_block > 0 && plan_held < plan_cap) begin
               plan_held++;
               plan_block--;
            end
         end
         KIND_READ: begin
            n = (len < plan_held) ? len : plan_held;
            if (n > BURST_LIMIT) n = BURST_LIMIT;
            plan_held -= n;
         end
         KIND_CLEAR: begin
            plan_held  = 0;
            plan_block = 0;
         end
         default: ;
      endcase
   endfunction

   function automatic void random_traffic(int count, int max_block);
      int made;
      int pick;
      int room;
      int blen;
      int nbytes;
      int r;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         room = plan_cap - plan_held;
         if (pick < 45) begin
            // well-formed block write, now and then one byte short or over
            blen = $urandom_range(0, (room < max_block) ? room : max_block);
            queue_op(KIND_OPEN, blen, $urandom_range(0, 255));
            nbytes = blen;
            r = $urandom_range(0, 9);
            if (r == 0 && nbytes > 0) nbytes--;
            if (r == 1) nbytes++;
            for (int k = 0; k < nbytes; k++)
               queue_op(KIND_WBYTE, $urandom_range(0, LEN_ALL_ONES), $urandom_range(0, 255));
            made += 1 + nbytes;
         end else if (pick < 85) begin
            if ($urandom_range(0, 3) == 0) blen = LEN_ALL_ONES;
            else blen = $urandom_range(0, plan_held + 4);
            queue_op((pick < 72) ? KIND_READ : KIND_PEEK, blen, $urandom_range(0, 255));
            made++;
         end else if (pick < 90) begin
            // oversized block, the bytes after it go nowhere
            queue_op(KIND_OPEN, $urandom_range(room + 1, LEN_ALL_ONES), 0);
            queue_op(KIND_WBYTE, $urandom_range(0, LEN_ALL_ONES), $urandom_range(0, 255));
            made += 2;
         end else if (pick < 94) begin
            queue_op(KIND_CLEAR, $urandom_range(0, LEN_ALL_ONES), $urandom_range(0, 255));
            made++;
         end else if (pick < 97) begin
            queue_op(KIND_WBYTE, $urandom_range(0, LEN_ALL_ONES), $urandom_range(0, 255));
            made++;
         end else begin
            queue_op(KIND_W'(KIND_SPARE5 + $urandom_range(0, 2)),
                     $urandom_range(0, LEN_ALL_ONES), $urandom_range(0, 255));
            made++;
         end
      end
   endfunction

   task automatic drain();
      while (op_q.size() != 0 || req_chan.valid || due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_capacity(int value);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= LEN_W'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      plan_cap   = (value > RING_DEPTH) ? RING_DEPTH : value;
      plan_held  = 0;
      plan_block = 0;
      cap_settings++;
   endtask

   task automatic set_idling(int send_gap, int take_stall);
      send_gap_pct   = send_gap;
      take_stall_pct = take_stall;
   endtask

   initial begin
      reset                   = 1'b1;
      csr_wr_en               = 1'b0;
      csr_wr_data             = '0;
      req_chan.valid          = 1'b0;
      req_chan.kind           = KIND_OPEN;
      req_chan.request_length = '0;
      req_chan.data_byte      = '0;
      rsp_chan.ready          = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero-size ring: nothing fits, nothing is held
      set_idling(0, 0);
      set_capacity(0);
      queue_op(KIND_OPEN, 0, 0);
      queue_op(KIND_WBYTE, LEN_ALL_ONES, 8'hFF);
      queue_op(KIND_READ, 5, 0);
      queue_op(KIND_PEEK, 0, 0);
      queue_op(KIND_SPARE7, LEN_ALL_ONES, 8'hFF);

      // oversized setting saturates to the full depth
      set_capacity(LEN_ALL_ONES);
      queue_op(KIND_OPEN, LEN_ALL_ONES, 0);
      queue_op(KIND_OPEN, RING_DEPTH, 0);
      queue_op(KIND_WBYTE, 0, 8'h00);
      queue_op(KIND_WBYTE, 0, 8'hFF);
      queue_op(KIND_WBYTE, 0, 8'h5A);
      queue_op(KIND_PEEK, LEN_ALL_ONES, 0);
      queue_op(KIND_READ, 1, 0);
      queue_op(KIND_OPEN, 3, 0);        // replaces the block still open
      queue_op(KIND_WBYTE, 0, 8'hA5);
      queue_op(KIND_READ, LEN_ALL_ONES, 0);
      queue_op(KIND_READ, 2, 0);
      queue_op(KIND_SPARE5, 0, 0);
      queue_op(KIND_SPARE6, 0, 0);
      queue_op(KIND_CLEAR, 0, 0);
      queue_op(KIND_WBYTE, 0, 8'h77);

      // one-byte ring: full at 100 percent, extra byte dropped
      set_capacity(1);
      queue_op(KIND_OPEN, 2, 0);
      queue_op(KIND_OPEN, 1, 0);
      queue_op(KIND_WBYTE, 0, 8'h3C);
      queue_op(KIND_WBYTE, 0, 8'hC3);
      queue_op(KIND_PEEK, 1, 0);
      queue_op(KIND_READ, 1, 0);

      set_capacity(5);
      set_idling(0, 0);
      random_traffic(30, 5);

      set_capacity(RING_DEPTH);
      set_idling(45, 0);
      random_traffic(45, 40);

      set_capacity($urandom_range(6, 40));
      set_idling(0, 45);
      random_traffic(30, 8);

      set_capacity(2);
      set_idling(25, 25);
      random_traffic(25, 2);

      // response side holds off while items keep coming, buffer backs up
      set_capacity(24);
      set_idling(0, 0);
      hold_len = 300;
      hold_req = ~hold_req;
      random_traffic(30, 10);

      set_capacity($urandom_range(30, 70));
      set_idling(25, 25);
      random_traffic(15, 12);

      drain();
      $display("Summary: %0d items over %0d ring sizes (empty, one byte, full depth, wrap,",
               item_count, cap_settings);
      $display("   refused blocks, peek, clear, stalls, hold-off); %0d results, %0d bytes.",
               checked_count, byte_count);
      if (fault_count == 0 && due_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* files.f */
rtl/core/brb_pkg.sv
rtl/core/brb_if.sv
rtl/core/brb_ram.sv
rtl/core/brb_queue.sv
rtl/core/brb_front.sv
rtl/core/brb_back.sv
rtl/core/byte_ring_buffer_all_or_nothing_write.sv
bench/byte_ring_buffer_all_or_nothing_write_tb.sv
